[sv/i2cra_pkg.sv]
// shared types and constants for the i2c register access core
`default_nettype none
package i2cra_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0, PH_ST1 = 4'd1, PH_ST2 = 4'd2, PH_TXL = 4'd3, PH_TXH = 4'd4,
    PH_AKL = 4'd5, PH_AKH = 4'd6, PH_POLL = 4'd7, PH_LOAD = 4'd8, PH_RXL = 4'd9,
    PH_RXH = 4'd10, PH_MAL = 4'd11, PH_MAH = 4'd12, PH_SP0 = 4'd13, PH_SP1 = 4'd14,
    PH_SP2 = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    SG_SLAVE = 3'd0, SG_REG = 3'd1, SG_WDATA = 3'd2, SG_RSLAVE = 3'd3, SG_RDATA = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0, KIND_WRITE = 2'd1, KIND_READ = 2'd2, KIND_SPARE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_WRITE_NACK = 2'd1, ST_READ_NACK = 2'd2
  } status_t;

  localparam logic [1:0] CFG_EDGE_HOLD = 2'd0;
  localparam logic [1:0] CFG_HALF_BIT  = 2'd1;
  localparam logic [1:0] CFG_ACK_POLL  = 2'd2;

  localparam logic [7:0] EDGE_HOLD_RESET = 8'd4;
  localparam logic [7:0] HALF_BIT_RESET  = 8'd1;
  localparam logic [7:0] ACK_POLL_RESET  = 8'd250;

  typedef struct packed {
    logic       is_cmd;
    logic       is_read;
    logic [7:0] slave_byte;
    logic [7:0] reg_address;
    logic [8:0] length;
    logic [7:0] write_data;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy;
    logic       data_request;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done;
    logic [1:0] status;
  } result_t;

endpackage
`default_nettype wire

[sv/i2cra_front.sv]
// input stage: classifies a tick and clamps the transfer length
`default_nettype none
module i2cra_front #(
  parameter int LenW = 9,
  parameter int MaxLength = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          kind,
  input  wire logic [7:0]          slave_byte,
  input  wire logic [7:0]          reg_address,
  input  wire logic [LenW-1:0]     transfer_length,
  input  wire logic [7:0]          write_data,
  input  wire logic                sda_in,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output i2cra_pkg::tick_t         q_item
);

  // a limit above the widest length never clamps
  localparam int ClampLen = (MaxLength > ((1 << LenW) - 1)) ? ((1 << LenW) - 1) : MaxLength;
  localparam logic [LenW:0] MaxLen = (LenW+1)'(ClampLen);

  logic            full;
  i2cra_pkg::tick_t held;
  i2cra_pkg::tick_t cls;
  logic [LenW:0]   len_clamp;

  always_comb begin
    len_clamp = {1'b0, transfer_length};
    if (len_clamp == '0) len_clamp = (LenW+1)'(1);
    if (len_clamp > MaxLen) len_clamp = MaxLen;
    cls.is_cmd      = (kind == i2cra_pkg::KIND_WRITE) || (kind == i2cra_pkg::KIND_READ);
    cls.is_read     = (kind == i2cra_pkg::KIND_READ);
    cls.slave_byte  = slave_byte;
    cls.reg_address = reg_address;
    cls.length      = 9'(len_clamp);
    cls.write_data  = write_data;
    cls.sda         = sda_in;
  end

  assign in_ready = !full || q_ready;
  assign q_valid  = full;
  assign q_item   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_ready && in_valid) held <= cls;
  end

endmodule
`default_nettype wire

[sv/i2cra_back.sv]
// bus sequencer: steps the i2c phases once per tick and registers the result
`default_nettype none
module i2cra_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  i2cra_pkg::tick_t       q_item,
  input  wire logic [7:0]        edge_hold,
  input  wire logic [7:0]        half_bit,
  input  wire logic [7:0]        poll_limit,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output i2cra_pkg::result_t     res
);

  i2cra_pkg::phase_t phase, phase_next;
  i2cra_pkg::stage_t stage, stage_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [8:0] bytes_left, bytes_left_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] ack_polls, ack_polls_next;
  logic       is_read, is_read_next;
  logic [7:0] held_slave, held_slave_next;
  logic [7:0] held_register, held_register_next;
  logic       failed, failed_next;
  i2cra_pkg::result_t r;
  i2cra_pkg::result_t res_next;
  logic       step;
  logic       hb_end, eh_end;
  logic [7:0] hb_d, eh_d;

  assign q_ready = !out_valid || out_ready;
  assign step    = q_valid && q_ready;
  assign hb_d    = (half_bit == 8'd0) ? 8'd1 : half_bit;
  assign eh_d    = (edge_hold == 8'd0) ? 8'd1 : edge_hold;
  assign hb_end  = ({1'b0, tick_count} + 9'd1) >= {1'b0, hb_d};
  assign eh_end  = ({1'b0, tick_count} + 9'd1) >= {1'b0, eh_d};

  // next state
  always_comb begin
    phase_next = phase; stage_next = stage; bit_index_next = bit_index;
    shift_byte_next = shift_byte; bytes_left_next = bytes_left;
    tick_count_next = tick_count; ack_polls_next = ack_polls; is_read_next = is_read;
    held_slave_next = held_slave; held_register_next = held_register;
    failed_next = failed;
    r = '0;
    case (phase)
      i2cra_pkg::PH_IDLE: begin
        if (q_item.is_cmd) begin
          is_read_next = q_item.is_read;
          held_slave_next = q_item.slave_byte;
          held_register_next = q_item.reg_address;
          bytes_left_next = q_item.length;
          stage_next = i2cra_pkg::SG_SLAVE;
          failed_next = 1'b0;
          bit_index_next = '0;
          tick_count_next = '0;
          phase_next = i2cra_pkg::PH_ST1;
        end
      end
      i2cra_pkg::PH_ST1: begin
        tick_count_next = eh_end ? 8'd0 : tick_count + 8'd1;
        if (eh_end) phase_next = i2cra_pkg::PH_ST2;
      end
      i2cra_pkg::PH_ST2: begin
        tick_count_next = eh_end ? 8'd0 : tick_count + 8'd1;
        if (eh_end) begin
          shift_byte_next = (stage == i2cra_pkg::SG_SLAVE) ? held_slave
                                                           : (held_slave | 8'h01);
          bit_index_next = '0;
          phase_next = i2cra_pkg::PH_TXL;
        end
      end
      i2cra_pkg::PH_TXL, i2cra_pkg::PH_AKL, i2cra_pkg::PH_RXL, i2cra_pkg::PH_MAL,
      i2cra_pkg::PH_SP0: begin
        tick_count_next = hb_end ? 8'd0 : tick_count + 8'd1;
        if (hb_end) begin
          case (phase)
            i2cra_pkg::PH_TXL: phase_next = i2cra_pkg::PH_TXH;
            i2cra_pkg::PH_AKL: phase_next = i2cra_pkg::PH_AKH;
            i2cra_pkg::PH_RXL: phase_next = i2cra_pkg::PH_RXH;
            i2cra_pkg::PH_MAL: phase_next = i2cra_pkg::PH_MAH;
            default:           phase_next = i2cra_pkg::PH_SP1;
          endcase
        end
      end
      i2cra_pkg::PH_TXH: begin
        tick_count_next = hb_end ? 8'd0 : tick_count + 8'd1;
        if (hb_end) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bit_index >= 4'd7) begin
            bit_index_next = '0;
            phase_next = i2cra_pkg::PH_AKL;
          end else begin
            bit_index_next = bit_index + 4'd1;
            phase_next = i2cra_pkg::PH_TXL;
          end
        end
      end
      i2cra_pkg::PH_AKH: begin
        tick_count_next = hb_end ? 8'd0 : tick_count + 8'd1;
        if (hb_end) begin
          ack_polls_next = '0;
          phase_next = i2cra_pkg::PH_POLL;
        end
      end
      i2cra_pkg::PH_POLL: begin
        if (!q_item.sda) begin
          tick_count_next = '0;
          case (stage)
            i2cra_pkg::SG_SLAVE: begin
              shift_byte_next = held_register;
              bit_index_next = '0;
              stage_next = i2cra_pkg::SG_REG;
              phase_next = i2cra_pkg::PH_TXL;
            end
            i2cra_pkg::SG_REG: begin
              if (is_read) begin
                stage_next = i2cra_pkg::SG_RSLAVE;
                phase_next = i2cra_pkg::PH_ST1;
              end else begin
                stage_next = i2cra_pkg::SG_WDATA;
                r.data_request = 1'b1;
                phase_next = i2cra_pkg::PH_LOAD;
              end
            end
            i2cra_pkg::SG_WDATA: begin
              if (bytes_left > 9'd1) begin
                bytes_left_next = bytes_left - 9'd1;
                r.data_request = 1'b1;
                phase_next = i2cra_pkg::PH_LOAD;
              end else begin
                bytes_left_next = '0;
                phase_next = i2cra_pkg::PH_SP0;
              end
            end
            default: begin
              stage_next = i2cra_pkg::SG_RDATA;
              shift_byte_next = '0;
              bit_index_next = '0;
              phase_next = i2cra_pkg::PH_RXL;
            end
          endcase
        end else if (ack_polls >= poll_limit) begin
          failed_next = 1'b1;
          tick_count_next = '0;
          phase_next = i2cra_pkg::PH_SP0;
        end else begin
          ack_polls_next = ack_polls + 8'd1;
        end
      end
      i2cra_pkg::PH_LOAD: begin
        shift_byte_next = q_item.write_data;
        bit_index_next = '0;
        tick_count_next = '0;
        phase_next = i2cra_pkg::PH_TXL;
      end
      i2cra_pkg::PH_RXH: begin
        if (tick_count == 8'd0) shift_byte_next = {shift_byte[6:0], q_item.sda};
        tick_count_next = hb_end ? 8'd0 : tick_count + 8'd1;
        if (hb_end) begin
          if (bit_index >= 4'd7) begin
            bit_index_next = '0;
            r.read_byte = shift_byte_next;
            r.read_valid = 1'b1;
            r.read_last = (bytes_left <= 9'd1);
            phase_next = i2cra_pkg::PH_MAL;
          end else begin
            bit_index_next = bit_index + 4'd1;
            phase_next = i2cra_pkg::PH_RXL;
          end
        end
      end
      i2cra_pkg::PH_MAH: begin
        tick_count_next = hb_end ? 8'd0 : tick_count + 8'd1;
        if (hb_end) begin
          if (bytes_left > 9'd1) begin
            bytes_left_next = bytes_left - 9'd1;
            shift_byte_next = '0;
            phase_next = i2cra_pkg::PH_RXL;
          end else begin
            phase_next = i2cra_pkg::PH_SP0;
          end
        end
      end
      i2cra_pkg::PH_SP1: begin
        tick_count_next = eh_end ? 8'd0 : tick_count + 8'd1;
        if (eh_end) phase_next = i2cra_pkg::PH_SP2;
      end
      i2cra_pkg::PH_SP2: begin
        tick_count_next = eh_end ? 8'd0 : tick_count + 8'd1;
        if (eh_end) begin
          r.done = 1'b1;
          r.status = !failed ? i2cra_pkg::ST_OK
                   : (is_read ? i2cra_pkg::ST_READ_NACK : i2cra_pkg::ST_WRITE_NACK);
          phase_next = i2cra_pkg::PH_IDLE;
        end
      end
      default: phase_next = i2cra_pkg::PH_IDLE;
    endcase
  end

  // line drives from the updated phase
  logic scl_d, sda_d;
  always_comb begin
    case (phase_next)
      i2cra_pkg::PH_ST2: begin scl_d = 1'b0; sda_d = 1'b1; end
      i2cra_pkg::PH_TXL: begin scl_d = 1'b1; sda_d = !shift_byte_next[7]; end
      i2cra_pkg::PH_TXH: begin scl_d = 1'b0; sda_d = !shift_byte_next[7]; end
      i2cra_pkg::PH_AKL, i2cra_pkg::PH_LOAD, i2cra_pkg::PH_RXL: begin
        scl_d = 1'b1; sda_d = 1'b0;
      end
      i2cra_pkg::PH_MAL: begin scl_d = 1'b1; sda_d = bytes_left_next > 9'd1; end
      i2cra_pkg::PH_MAH: begin scl_d = 1'b0; sda_d = bytes_left_next > 9'd1; end
      i2cra_pkg::PH_SP0: begin scl_d = 1'b1; sda_d = 1'b1; end
      i2cra_pkg::PH_SP1: begin scl_d = 1'b0; sda_d = 1'b1; end
      default:           begin scl_d = 1'b0; sda_d = 1'b0; end
    endcase
  end

  always_comb begin
    res_next = r;
    res_next.scl_low = scl_d;
    res_next.sda_low = sda_d;
    res_next.busy = (phase_next != i2cra_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cra_pkg::PH_IDLE; stage <= i2cra_pkg::SG_SLAVE;
      bit_index <= '0; shift_byte <= '0; bytes_left <= '0; tick_count <= '0;
      ack_polls <= '0; is_read <= 1'b0; held_slave <= '0; held_register <= '0;
      failed <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (q_ready) out_valid <= q_valid;
      if (step) begin
        phase <= phase_next; stage <= stage_next; bit_index <= bit_index_next;
        shift_byte <= shift_byte_next; bytes_left <= bytes_left_next;
        tick_count <= tick_count_next; ack_polls <= ack_polls_next;
        is_read <= is_read_next; held_slave <= held_slave_next;
        held_register <= held_register_next; failed <= failed_next;
      end
    end
    if (step) res <= res_next;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && r.done |=> phase == i2cra_pkg::PH_IDLE) else $error("done not idle");
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'd7) else $error("bit index range");
  a_rx_one: assert property (@(posedge clk) disable iff (rst)
    !(r.read_valid && r.done)) else $error("read and done together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase)) else $error("phase moved without item");
`endif

endmodule
`default_nettype wire

[sv/i2c_master_register_access_core.sv]
// top level of the i2c master register access core
`default_nettype none
// I2C master for register write and read transactions. Each accepted input item
// is one timing tick: it carries the sampled SDA level and, when idle, can start a
// command. Every item yields exactly one result item with the open-drain drives,
// status, data request and received byte. One item per clock is sustained; the
// flow stalls only when the output is held off. An item passes a one-entry input
// queue and then the sequencer's output register before its result appears.
module i2c_master_register_access_core #(
  parameter int MAX_LENGTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] slave_byte,
  input  wire logic [7:0] reg_address,
  input  wire logic [8:0] transfer_length,
  input  wire logic [7:0] write_data,
  input  wire logic       sda_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_low,
  output logic            sda_low,
  output logic            busy_res,
  output logic            data_request,
  output logic [7:0]      read_byte_out,
  output logic            read_valid,
  output logic            read_last,
  output logic            done_res,
  output logic [1:0]      status
);

  logic [7:0] edge_hold, half_bit, poll_limit;
  logic q_valid, q_ready;
  i2cra_pkg::tick_t q_item;
  i2cra_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_hold  <= i2cra_pkg::EDGE_HOLD_RESET;
      half_bit   <= i2cra_pkg::HALF_BIT_RESET;
      poll_limit <= i2cra_pkg::ACK_POLL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cra_pkg::CFG_EDGE_HOLD: edge_hold  <= cfg_data;
        i2cra_pkg::CFG_HALF_BIT:  half_bit   <= cfg_data;
        i2cra_pkg::CFG_ACK_POLL:  poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cra_front #(.LenW(9), .MaxLength(MAX_LENGTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .kind, .slave_byte, .reg_address,
    .transfer_length, .write_data, .sda_in, .q_valid, .q_ready, .q_item
  );

  i2cra_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .edge_hold, .half_bit, .poll_limit,
    .out_valid, .out_ready, .res
  );

  assign scl_low       = res.scl_low;
  assign sda_low       = res.sda_low;
  assign busy_res      = res.busy;
  assign data_request  = res.data_request;
  assign read_byte_out = res.read_byte;
  assign read_valid    = res.read_valid;
  assign read_last     = res.read_last;
  assign done_res      = res.done;
  assign status        = res.status;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// testbench for the i2c master register access core: tick-level prediction and checking
module tb_top;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = i2cra_pkg::CFG_EDGE_HOLD;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = i2cra_pkg::KIND_TICK;
  logic [7:0] slave_byte = '0;
  logic [7:0] reg_address = '0;
  logic [8:0] transfer_length = '0;
  logic [7:0] write_data = '0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl_low, sda_low, busy_res, data_request, read_valid, read_last, done_res;
  logic [7:0] read_byte_out;
  logic [1:0] status;

  i2c_master_register_access_core u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // sequencer shadow state
  i2cra_pkg::phase_t ph;
  i2cra_pkg::stage_t sg;
  int         bit_idx, left, tcnt, polls;
  logic [7:0] shreg, held_sl, held_rg;
  logic       rd, failed;
  logic [7:0] edge_hold, half_bit, poll_limit;

  i2cra_pkg::result_t expected_q[$];
  int      errors = 0;
  int      stall_cnt = 0;
  int      hold_cnt = 0;
  bit      no_idle = 0;
  bit      nack_mode = 0;
  int      sent_ticks = 0;

  function automatic bit phase_over(logic [7:0] dur);
    int d;
    d = (dur == 0) ? 1 : dur;
    if (tcnt + 1 >= d) begin
      tcnt = 0;
      return 1'b1;
    end
    tcnt++;
    return 1'b0;
  endfunction

  function automatic void enter(i2cra_pkg::phase_t p);
    ph = p;
    tcnt = 0;
  endfunction

  // returns the data request flag
  function automatic logic ack_seen();
    logic dreq;
    dreq = 1'b0;
    case (sg)
      i2cra_pkg::SG_SLAVE: begin
        shreg = held_rg;
        bit_idx = 0;
        sg = i2cra_pkg::SG_REG;
        enter(i2cra_pkg::PH_TXL);
      end
      i2cra_pkg::SG_REG: begin
        if (rd) begin
          sg = i2cra_pkg::SG_RSLAVE;
          enter(i2cra_pkg::PH_ST1);
        end else begin
          sg = i2cra_pkg::SG_WDATA;
          dreq = 1'b1;
          enter(i2cra_pkg::PH_LOAD);
        end
      end
      i2cra_pkg::SG_WDATA: begin
        if (left > 0) left--;
        if (left > 0) begin
          dreq = 1'b1;
          enter(i2cra_pkg::PH_LOAD);
        end else begin
          enter(i2cra_pkg::PH_SP0);
        end
      end
      default: begin
        sg = i2cra_pkg::SG_RDATA;
        shreg = '0;
        bit_idx = 0;
        enter(i2cra_pkg::PH_RXL);
      end
    endcase
    return dreq;
  endfunction

  function automatic i2cra_pkg::result_t bus_tick(logic [1:0] k, logic [7:0] sb,
                                                  logic [7:0] ra, logic [8:0] len,
                                                  logic [7:0] wd, logic sda);
    i2cra_pkg::result_t r;
    int      n;
    r = '0;
    case (ph)
      i2cra_pkg::PH_IDLE: begin
        if (k == i2cra_pkg::KIND_WRITE || k == i2cra_pkg::KIND_READ) begin
          n = (len == 0) ? 1 : int'(len);
          if (n > 256) n = 256;
          rd = (k == i2cra_pkg::KIND_READ);
          held_sl = sb;
          held_rg = ra;
          left = n;
          sg = i2cra_pkg::SG_SLAVE;
          failed = 1'b0;
          bit_idx = 0;
          enter(i2cra_pkg::PH_ST1);
        end
      end
      i2cra_pkg::PH_ST1: if (phase_over(edge_hold)) ph = i2cra_pkg::PH_ST2;
      i2cra_pkg::PH_ST2: begin
        if (phase_over(edge_hold)) begin
          shreg = (sg == i2cra_pkg::SG_SLAVE) ? held_sl : (held_sl | 8'h01);
          bit_idx = 0;
          ph = i2cra_pkg::PH_TXL;
        end
      end
      i2cra_pkg::PH_TXL: if (phase_over(half_bit)) ph = i2cra_pkg::PH_TXH;
      i2cra_pkg::PH_TXH: begin
        if (phase_over(half_bit)) begin
          shreg = {shreg[6:0], 1'b0};
          bit_idx++;
          if (bit_idx >= 8) begin
            bit_idx = 0;
            ph = i2cra_pkg::PH_AKL;
          end else begin
            ph = i2cra_pkg::PH_TXL;
          end
        end
      end
      i2cra_pkg::PH_AKL: if (phase_over(half_bit)) ph = i2cra_pkg::PH_AKH;
      i2cra_pkg::PH_AKH: begin
        if (phase_over(half_bit)) begin
          polls = 0;
          ph = i2cra_pkg::PH_POLL;
        end
      end
      i2cra_pkg::PH_POLL: begin
        if (!sda) begin
          r.data_request = ack_seen();
        end else if (polls >= int'(poll_limit)) begin
          failed = 1'b1;
          enter(i2cra_pkg::PH_SP0);
        end else begin
          polls++;
        end
      end
      i2cra_pkg::PH_LOAD: begin
        shreg = wd;
        bit_idx = 0;
        enter(i2cra_pkg::PH_TXL);
      end
      i2cra_pkg::PH_RXL: if (phase_over(half_bit)) ph = i2cra_pkg::PH_RXH;
      i2cra_pkg::PH_RXH: begin
        if (tcnt == 0) shreg = {shreg[6:0], sda};
        if (phase_over(half_bit)) begin
          bit_idx++;
          if (bit_idx >= 8) begin
            bit_idx = 0;
            r.read_byte = shreg;
            r.read_valid = 1'b1;
            r.read_last = (left <= 1);
            ph = i2cra_pkg::PH_MAL;
          end else begin
            ph = i2cra_pkg::PH_RXL;
          end
        end
      end
      i2cra_pkg::PH_MAL: if (phase_over(half_bit)) ph = i2cra_pkg::PH_MAH;
      i2cra_pkg::PH_MAH: begin
        if (phase_over(half_bit)) begin
          if (left > 1) begin
            left--;
            shreg = '0;
            ph = i2cra_pkg::PH_RXL;
          end else begin
            ph = i2cra_pkg::PH_SP0;
          end
        end
      end
      i2cra_pkg::PH_SP0: if (phase_over(half_bit)) ph = i2cra_pkg::PH_SP1;
      i2cra_pkg::PH_SP1: if (phase_over(edge_hold)) ph = i2cra_pkg::PH_SP2;
      i2cra_pkg::PH_SP2: begin
        if (phase_over(edge_hold)) begin
          r.done = 1'b1;
          r.status = failed ? (rd ? i2cra_pkg::ST_READ_NACK : i2cra_pkg::ST_WRITE_NACK)
                            : i2cra_pkg::ST_OK;
          ph = i2cra_pkg::PH_IDLE;
        end
      end
      default: enter(i2cra_pkg::PH_IDLE);
    endcase
    case (ph)
      i2cra_pkg::PH_ST2: begin r.scl_low = 1'b0; r.sda_low = 1'b1; end
      i2cra_pkg::PH_TXL: begin r.scl_low = 1'b1; r.sda_low = !shreg[7]; end
      i2cra_pkg::PH_TXH: begin r.scl_low = 1'b0; r.sda_low = !shreg[7]; end
      i2cra_pkg::PH_AKL, i2cra_pkg::PH_LOAD, i2cra_pkg::PH_RXL: begin
        r.scl_low = 1'b1; r.sda_low = 1'b0;
      end
      i2cra_pkg::PH_MAL: begin r.scl_low = 1'b1; r.sda_low = (left > 1); end
      i2cra_pkg::PH_MAH: begin r.scl_low = 1'b0; r.sda_low = (left > 1); end
      i2cra_pkg::PH_SP0: begin r.scl_low = 1'b1; r.sda_low = 1'b1; end
      i2cra_pkg::PH_SP1: begin r.scl_low = 1'b0; r.sda_low = 1'b1; end
      default: begin r.scl_low = 1'b0; r.sda_low = 1'b0; end
    endcase
    r.busy = (ph != i2cra_pkg::PH_IDLE);
    return r;
  endfunction

  // one tick item: hold until accepted, then predict
  task automatic send_tick(logic [1:0] k, logic [7:0] sb, logic [7:0] ra,
                           logic [8:0] len, logic [7:0] wd, logic sda);
    if (!no_idle && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    slave_byte <= sb;
    reg_address <= ra;
    transfer_length <= len;
    write_data <= wd;
    sda_in <= sda;
    do @(posedge clk); while (!in_ready);
    if (ph == i2cra_pkg::PH_IDLE &&
        (k == i2cra_pkg::KIND_WRITE || k == i2cra_pkg::KIND_READ)) nack_mode = 0;
    expected_q.push_back(bus_tick(k, sb, ra, len, wd, sda));
    sent_ticks++;
  endtask

  function automatic logic slave_sda();
    if (ph == i2cra_pkg::PH_POLL) return nack_mode ? 1'b1 : ($urandom_range(0, 5) == 0);
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [8:0] pick_length();
    int p;
    p = $urandom_range(0, 199);
    if (p == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, 3));
  endfunction

  task automatic random_tick();
    logic [1:0] k;
    if (ph == i2cra_pkg::PH_IDLE) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, 1) ? i2cra_pkg::KIND_WRITE : i2cra_pkg::KIND_READ;
      end else begin
        k = $urandom_range(0, 1) ? i2cra_pkg::KIND_TICK : i2cra_pkg::KIND_SPARE;
      end
      send_tick(k, 8'($urandom), 8'($urandom), pick_length(), 8'($urandom),
                1'($urandom_range(0, 1)));
      if (k == i2cra_pkg::KIND_WRITE || k == i2cra_pkg::KIND_READ)
        nack_mode = ($urandom_range(0, 9) == 0);
    end else begin
      send_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 9'($urandom),
                8'($urandom), slave_sda());
    end
  endtask

  task automatic command(logic [1:0] k, logic [7:0] sb, logic [7:0] ra, logic [8:0] len,
                         bit nack);
    send_tick(k, sb, ra, len, 8'($urandom), 1'b1);
    nack_mode = nack;
    while (ph != i2cra_pkg::PH_IDLE) random_tick();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    while (ph != i2cra_pkg::PH_IDLE) random_tick();
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      i2cra_pkg::CFG_EDGE_HOLD: edge_hold = val;
      i2cra_pkg::CFG_HALF_BIT:  half_bit = val;
      i2cra_pkg::CFG_ACK_POLL:  poll_limit = val;
      default: ;
    endcase
  endtask

  task automatic test_defaults();
    command(i2cra_pkg::KIND_WRITE, 8'hA0, 8'h00, 9'd0, 0);
    command(i2cra_pkg::KIND_READ, 8'hFF, 8'hFF, 9'd1, 0);
    command(i2cra_pkg::KIND_WRITE, 8'h00, 8'h5A, 9'd2, 1);
    command(i2cra_pkg::KIND_SPARE, 8'h12, 8'h34, 9'd1, 0);
    send_tick(i2cra_pkg::KIND_TICK, 8'h00, 8'h00, 9'd0, 8'h00, 1'b0);
  endtask

  task automatic test_long_transfers();
    write_cfg(i2cra_pkg::CFG_ACK_POLL, 8'd1);
    command(i2cra_pkg::KIND_READ, 8'h3C, 8'hC3, 9'd3, 0);
    command(i2cra_pkg::KIND_WRITE, 8'hC3, 8'h3C, 9'h1FF, 1);
  endtask

  task automatic test_slow_timing();
    write_cfg(i2cra_pkg::CFG_EDGE_HOLD, 8'd8);
    write_cfg(i2cra_pkg::CFG_HALF_BIT, 8'd2);
    write_cfg(i2cra_pkg::CFG_ACK_POLL, 8'd2);
    command(i2cra_pkg::KIND_READ, 8'h7E, 8'hE7, 9'd1, 1);
  endtask

  task automatic test_zero_timing();
    write_cfg(i2cra_pkg::CFG_EDGE_HOLD, 8'd0);
    write_cfg(i2cra_pkg::CFG_HALF_BIT, 8'd0);
    write_cfg(i2cra_pkg::CFG_ACK_POLL, 8'd0);
    command(i2cra_pkg::KIND_WRITE, 8'h81, 8'h18, 9'd1, 0);
  endtask

  task automatic test_random_mix();
    for (int r = 0; r < 3; r++) begin
      write_cfg(i2cra_pkg::CFG_EDGE_HOLD, 8'($urandom_range(1, 2)));
      write_cfg(i2cra_pkg::CFG_HALF_BIT, 8'($urandom_range(1, 2)));
      write_cfg(i2cra_pkg::CFG_ACK_POLL, (r == 0) ? 8'd1 : 8'($urandom_range(1, 6)));
      no_idle = (r == 1);
      repeat (30) random_tick();
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    hold_cnt = HOLD_CYCLES;
    repeat (100) random_tick();
    drain();
    repeat (30) random_tick();
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    i2cra_pkg::result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result item", $time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("scl_low", e.scl_low, scl_low);
        check_field("sda_low", e.sda_low, sda_low);
        check_field("busy_res", e.busy, busy_res);
        check_field("data_request", e.data_request, data_request);
        check_field("read_byte_out", e.read_byte, read_byte_out);
        check_field("read_valid", e.read_valid, read_valid);
        check_field("read_last", e.read_last, read_last);
        check_field("done_res", e.done, done_res);
        check_field("status", e.status, status);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    ph = i2cra_pkg::PH_IDLE;
    sg = i2cra_pkg::SG_SLAVE;
    bit_idx = 0; left = 0; tcnt = 0; polls = 0;
    shreg = '0; held_sl = '0; held_rg = '0; rd = 0; failed = 0;
    edge_hold = i2cra_pkg::EDGE_HOLD_RESET;
    half_bit = i2cra_pkg::HALF_BIT_RESET;
    poll_limit = i2cra_pkg::ACK_POLL_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_long_transfers();
    test_slow_timing();
    test_zero_timing();
    test_random_mix();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
